// ===== hdl/fspa_pkg.sv =====
// package for the fixed slot pool allocator
// holds the word types, status codes and controller/datapath interface structs
// no dependencies
`default_nettype none

package fspa_pkg;

    localparam int ADDR_W    = 32;
    localparam int CHUNK_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 1'b0,
        CFG_CHUNK_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FREED   = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] free_address;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] object_address;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic alloc_pop;
        logic div_start;
        logic rd_slot;
        logic free_push;
        logic fix;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic head_nil;
        logic range_ok;
        logic div_done;
        logic rem_zero;
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fspa_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module fspa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_div.sv =====
// restoring divider, one quotient bit per cycle
// used for the slot index and alignment check; no dependencies
`default_nettype none

module fspa_div #(
    parameter int OFF_W = 16,
    parameter int DIV_W = 13,
    parameter int QW    = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [OFF_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [QW-1:0]    quotient,
    output logic                  rem_zero,
    output logic                  done
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [OFF_W-1:0] rem_reg;
    logic [OFF_W-1:0] dvs_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [OFF_W-1:0] diff;
    logic             borrow;

    assign {borrow, diff} = {1'b0, rem_reg} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= CNT_W'(QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= OFF_W'(divisor) << (QW - 1);
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (!borrow)
            begin
                rem_reg <= diff;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= (quo_reg << 1) | QW'(!borrow);
        end
    end

    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_dp.sv =====
// datapath: config registers, free list head, link rams, address checks
// depends on fspa_pkg, fspa_ram and fspa_div
`default_nettype none

module fspa_dp
    import fspa_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire request_t             request,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    output logic      [ADDR_W-1:0]    obj_addr
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int OFF_W  = SW + CHUNK_W;
    localparam int PROD_W = IDX_W + CHUNK_W;
    localparam int WIDE_W = ADDR_W + 2;

    localparam logic [IDX_W-1:0]  NIL       = IDX_W'(SLOTS);
    localparam logic [IDX_W-1:0]  TOP_SLOT  = IDX_W'(SLOTS - 1);
    localparam logic [SW-1:0]     LAST_CLR  = SW'(SLOTS - 1);
    localparam logic [WIDE_W-1:0] HDR_WIDE  = WIDE_W'(HEADER_BYTES);
    localparam logic [WIDE_W-1:0] SLOT_WIDE = WIDE_W'(SLOTS);

    logic [ADDR_W-1:0]  base_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [SW-1:0]      clr_cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]   fix_idx_reg;
    logic [IDX_W-1:0]   fix_val_reg;
    logic [ADDR_W-1:0]  obj_reg;

    logic [WIDE_W-1:0]  addr_wide;
    logic [WIDE_W-1:0]  lower;
    logic [WIDE_W-1:0]  limit;
    logic [WIDE_W-1:0]  off_wide;
    logic [SW-1:0]      quotient;
    logic [IDX_W-1:0]   q_idx;
    logic               div_done;
    logic               rem_zero;

    logic               next_we;
    logic [SW-1:0]      next_waddr;
    logic [IDX_W-1:0]   next_wdata;
    logic               prev_we;
    logic [SW-1:0]      prev_waddr;
    logic [IDX_W-1:0]   prev_wdata;
    logic [SW-1:0]      rd_addr;
    logic [IDX_W-1:0]   next_rd;
    logic [IDX_W-1:0]   prev_rd;

    // range check, exact in wide arithmetic
    assign addr_wide = WIDE_W'(addr_reg);
    assign lower     = WIDE_W'(base_reg) + HDR_WIDE;
    assign limit     = WIDE_W'(base_reg) + SLOT_WIDE * WIDE_W'(chunk_reg);
    assign off_wide  = addr_wide - lower;

    fspa_div #(
        .OFF_W (OFF_W),
        .DIV_W (CHUNK_W),
        .QW    (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (off_wide[OFF_W-1:0]),
        .divisor  (chunk_reg),
        .quotient (quotient),
        .rem_zero (rem_zero),
        .done     (div_done)
    );

    assign q_idx   = IDX_W'(quotient);
    assign rd_addr = cmd.rd_slot ? quotient : head_reg[SW-1:0];

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = head_reg[SW-1:0];
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = head_reg[SW-1:0];
        prev_wdata = NIL;
        if (cmd.clear_step)
        begin
            next_we    = 1'b1;
            next_waddr = clr_cnt_reg;
            next_wdata = (clr_cnt_reg == '0) ? NIL : IDX_W'(clr_cnt_reg) - 1'b1;
            prev_we    = 1'b1;
            prev_waddr = clr_cnt_reg;
            prev_wdata = (clr_cnt_reg == LAST_CLR) ? NIL : IDX_W'(clr_cnt_reg) + 1'b1;
        end
        else if (cmd.alloc_pop)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end
        else if (cmd.free_push)
        begin
            next_we    = 1'b1;
            next_waddr = quotient;
            next_wdata = head_reg;
            prev_we    = 1'b1;
            prev_waddr = quotient;
        end
        else if (cmd.fix)
        begin
            prev_we    = (fix_idx_reg != NIL);
            prev_waddr = fix_idx_reg[SW-1:0];
            prev_wdata = fix_val_reg;
        end
    end

    fspa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    fspa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            chunk_reg   <= CHUNK_RESET;
            head_reg    <= TOP_SLOT;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POOL_BASE:   base_reg  <= cfg_data;
                    CFG_CHUNK_BYTES: chunk_reg <= cfg_data[CHUNK_W-1:0];
                    default:         base_reg  <= base_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.alloc_pop)
            begin
                head_reg <= next_rd;
            end
            else if (cmd.free_push)
            begin
                head_reg <= q_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= request.free_address;
            prod_reg <= PROD_W'(head_reg) * PROD_W'(chunk_reg);
        end
        if (cmd.alloc_pop)
        begin
            fix_idx_reg <= next_rd;
            fix_val_reg <= NIL;
            obj_reg     <= base_reg + ADDR_W'(prod_reg) + ADDR_W'(HEADER_BYTES);
        end
        else if (cmd.free_push)
        begin
            fix_idx_reg <= head_reg;
            fix_val_reg <= q_idx;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == LAST_CLR);
    assign stat.head_nil   = (head_reg == NIL);
    assign stat.range_ok   = (chunk_reg != '0) && (addr_wide >= lower) && (addr_wide < limit);
    assign stat.div_done   = div_done;
    assign stat.rem_zero   = rem_zero;
    assign stat.slot_free  = (next_rd == NIL) && (prev_rd == NIL) && (head_reg != q_idx);
    assign obj_addr        = obj_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_ctrl.sv =====
// controller state machine: sequences clear pass, alloc and free
// depends on fspa_pkg
`default_nettype none

module fspa_ctrl
    import fspa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     mode,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          done,
    output status_t       status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WAIT,
        S_A_FIX,
        S_F_RANGE,
        S_F_DIV,
        S_F_WAIT,
        S_F_FIX
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    done_reg;
    logic    done_next;
    status_t status_reg;
    status_t status_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (mode == MODE_FREE)
                    begin
                        state_next = S_F_RANGE;
                    end
                    else if (stat.head_nil)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_A_WAIT;
                    end
                end
            end
            S_A_WAIT:
            begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_A_FIX;
            end
            S_A_FIX:
            begin
                cmd.fix     = 1'b1;
                done_next   = 1'b1;
                status_next = ST_ALLOC;
                state_next  = S_IDLE;
            end
            S_F_RANGE:
            begin
                if (stat.range_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_F_DIV;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_INVALID;
                    state_next  = S_IDLE;
                end
            end
            S_F_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.rd_slot = 1'b1;
                        state_next  = S_F_WAIT;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_INVALID;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_F_WAIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.free_push = 1'b1;
                    state_next    = S_F_FIX;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_DOUBLE;
                    state_next  = S_IDLE;
                end
            end
            S_F_FIX:
            begin
                cmd.fix     = 1'b1;
                done_next   = 1'b1;
                status_next = ST_FREED;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            done_reg   <= 1'b0;
            status_reg <= ST_ALLOC;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ===== hdl/fixed_slot_pool_allocator.sv =====
// fixed slot pool allocator: alloc pops the free list head and then fixes the link of the new head
// free runs the range check, the bit-serial slot divider with the alignment check, a double-free check, then the push
// an empty pool answers an alloc in the next cycle; busy drops with done, results cannot be stalled
// after reset the link rams are rewritten, one slot a cycle, while busy is high
// depends on fspa_pkg, fspa_ctrl and fspa_dp
`default_nettype none

module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire request_t             request,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    status_t           status;
    logic [ADDR_W-1:0] obj_addr;

    fspa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (request.mode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    fspa_dp #(
        .SLOTS        (SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .obj_addr  (obj_addr)
    );

    assign result.object_address = (status == ST_ALLOC) ? obj_addr : '0;
    assign result.status         = status;

endmodule

`default_nettype wire

// ===== hdl/fspa_checker.sv =====
// port level checks for the pool allocator, bound to the top level
// depends on fspa_pkg and fixed_slot_pool_allocator
`default_nettype none

module fspa_checker
    import fspa_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     done,
    input wire result_t  result
);

    // a result word is only shown while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // only an allocation carries an address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_ALLOC) |-> (result.object_address == '0))
        else $error("non-zero address without allocation");

    // an accepted word is either answered at once or keeps the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word dropped");

    // a free needs the range check first, never answered next cycle
    a_free_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.mode == MODE_FREE) |=> !done)
        else $error("free answered too early");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire
